>>> rtl/eid_prefix_best_match_top_macros.svh
// ----------------------------------------------------------------------------
// eid_prefix_best_match_top_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef EID_PREFIX_BEST_MATCH_TOP_MACROS_SVH
`define EID_PREFIX_BEST_MATCH_TOP_MACROS_SVH

// same-cycle implication
`define EPBM_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("epbm assertion failed");

// next-cycle implication
`define EPBM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("epbm assertion failed");

`endif

>>> rtl/epbm_pkg.sv
// ----------------------------------------------------------------------------
// epbm_pkg
// types, constants and helpers of the prefix best-match block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epbm_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam int SLOT_W      = 5;
  localparam int LEN_W       = 8;
  localparam int HALF_W      = 64;
  localparam int ADDR_W      = 128;
  localparam int V4_BITS     = 32;
  localparam int V6_BITS     = 128;
  localparam int MASK_W      = 32;
  localparam int OCNT_W      = 6;
  localparam int CHUNK_W     = 8;
  localparam int N_CHUNKS    = ADDR_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(N_CHUNKS);
  localparam int LZ_W        = $clog2(CHUNK_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;
  localparam logic FAM_V4     = 1'b0;
  localparam logic FAM_V6     = 1'b1;

  typedef enum logic [1:0] {
    KIND_DROP   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic               present;
    logic               family;
    logic [LEN_W-1:0]   length;
    logic [HALF_W-1:0]  upper;
    logic [HALF_W-1:0]  lower;
  } work_t;

  typedef struct packed {
    logic               family;
    logic [LEN_W-1:0]   length;
    logic [HALF_W-1:0]  upper;
    logic [HALF_W-1:0]  lower;
  } entry_t;

  // leading zeros of one byte; an all-zero byte is flagged elsewhere
  function automatic logic [LZ_W-1:0] lzc8(input logic [CHUNK_W-1:0] x);
    logic [LZ_W-1:0] n;
    logic            seen;
    n    = '0;
    seen = 1'b0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      if (!seen && !x[b]) begin
        n = n + 1'b1;
      end else begin
        seen = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/epbm_front.sv
// ----------------------------------------------------------------------------
// epbm_front
// accepts items, sorts them into writes, lookups and ignored writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epbm_front #(
  parameter int TABLE_DEPTH = epbm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        push,
  output logic                        full,
  input  logic                        in_cmd,
  input  logic [epbm_pkg::SLOT_W-1:0] in_entry_slot,
  input  logic                        in_slot_valid,
  input  logic                        in_addr_family,
  input  logic [epbm_pkg::LEN_W-1:0]  in_prefix_length,
  input  logic [epbm_pkg::HALF_W-1:0] in_addr_upper,
  input  logic [epbm_pkg::HALF_W-1:0] in_addr_lower,
  output logic                        q_push,
  output epbm_pkg::work_t             q_item,
  input  logic                        q_full
);
  import epbm_pkg::*;

  localparam logic [SLOT_W:0] DEPTH_V = (SLOT_W + 1)'(TABLE_DEPTH);

  kind_t kind;

  always_comb begin
    if (in_cmd == CMD_LOOKUP) begin
      kind = KIND_LOOKUP;
    end else if ({1'b0, in_entry_slot} < DEPTH_V) begin
      kind = KIND_WRITE;
    end else begin
      kind = KIND_DROP;
    end
  end

  always_comb begin
    q_item.kind    = kind;
    q_item.slot    = in_entry_slot;
    q_item.present = in_slot_valid;
    q_item.family  = in_addr_family;
    q_item.length  = in_prefix_length;
    q_item.upper   = in_addr_upper;
    q_item.lower   = in_addr_lower;
  end

  // writes beyond the table are taken and dropped here
  assign full   = q_full;
  assign q_push = push && !q_full && (kind != KIND_DROP);

endmodule

>>> rtl/epbm_queue.sv
// ----------------------------------------------------------------------------
// epbm_queue
// short item queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epbm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  epbm_pkg::work_t item_in,
  output logic            full,
  input  logic            pop,
  output epbm_pkg::work_t item_out,
  output logic            empty
);
  import epbm_pkg::*;

  work_t             ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= item_in;
    end
  end

  assign item_out = ent_r[rd_ptr_r];

endmodule

>>> rtl/epbm_back.sv
// ----------------------------------------------------------------------------
// epbm_back
// entry table, scan pipeline and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epbm_back #(
  parameter int TABLE_DEPTH = epbm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  epbm_pkg::work_t             q_item,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_found,
  output logic [epbm_pkg::SLOT_W-1:0] out_first_winner,
  output logic [epbm_pkg::MASK_W-1:0] out_winner_mask,
  output logic [epbm_pkg::OCNT_W-1:0] out_winner_count,
  output logic [epbm_pkg::LEN_W-1:0]  out_common_bits,
  output logic [epbm_pkg::LEN_W-1:0]  out_best_length
);
  import epbm_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WCNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // table
  logic [TABLE_DEPTH-1:0] present_r;
  entry_t                 tbl_mem_r [TABLE_DEPTH];
  entry_t                 rd_data_r;

  // key of the running lookup
  logic                   key_fam_r;
  logic [HALF_W-1:0]      key_upper_r;
  logic [HALF_W-1:0]      key_lower_r;

  logic [IDX_W-1:0]       iss_r, iss_nxt;

  // scan pipeline
  logic                   p1_v_r, p1_hit_r;
  logic [IDX_W-1:0]       p1_idx_r;
  logic                   p2_v_r, p2_ok_r;
  logic [LEN_W-1:0]       p2_len_r;
  logic [IDX_W-1:0]       p2_idx_r;
  logic [N_CHUNKS-1:0]    p2_nz_r;
  logic [LZ_W-1:0]        p2_lz_r [N_CHUNKS];
  logic                   p3_v_r, p3_q_r;
  logic [LEN_W-1:0]       p3_c_r, p3_len_r;
  logic [IDX_W-1:0]       p3_idx_r;

  // running best
  logic                   any_r;
  logic [LEN_W-1:0]       best_c_r, best_len_r;
  logic [TABLE_DEPTH-1:0] mask_r;
  logic [WCNT_W-1:0]      wcnt_r;
  logic [IDX_W-1:0]       first_r;

  // result register
  logic                   out_v_r;
  logic                   out_found_r;
  logic [SLOT_W-1:0]      out_first_r;
  logic [MASK_W-1:0]      out_mask_r;
  logic [OCNT_W-1:0]      out_cnt_r;
  logic [LEN_W-1:0]       out_common_r;
  logic [LEN_W-1:0]       out_len_r;

  logic                   wr_en, start, issue, last_iss, pipe_busy, out_free, finish;
  logic [IDX_W-1:0]       wr_idx;
  logic [ADDR_W-1:0]      diff;
  logic [N_CHUNKS-1:0]    nz;
  logic [LZ_W-1:0]        lz [N_CHUNKS];
  logic                   fam_eq;
  logic [LEN_W-1:0]       cnt;
  logic                   seen_nz;
  logic                   qual;
  logic                   better, tie;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign wr_en     = q_pop && (q_item.kind == KIND_WRITE);
  assign start     = q_pop && (q_item.kind == KIND_LOOKUP);
  assign wr_idx    = q_item.slot[IDX_W-1:0];
  assign issue     = (state_r == ST_SCAN);
  assign last_iss  = (iss_r == IDX_W'(TABLE_DEPTH - 1));
  assign pipe_busy = p1_v_r || p2_v_r || p3_v_r;
  assign out_free  = !out_v_r || pop;
  assign finish    = (state_r == ST_DRAIN) && !pipe_busy && out_free;

  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    case (state_r)
      ST_IDLE: begin
        iss_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_iss) begin
          state_nxt = ST_DRAIN;
        end else begin
          iss_nxt = iss_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= '0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr_en) begin
      present_r[wr_idx] <= q_item.present;
    end
  end

  // single-port table: one write or one scan read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem_r[wr_idx] <= '{family: q_item.family, length: q_item.length,
                             upper: q_item.upper, lower: q_item.lower};
    end
    rd_data_r <= tbl_mem_r[iss_r];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_fam_r   <= q_item.family;
      key_upper_r <= q_item.upper;
      key_lower_r <= q_item.lower;
    end
  end

  // stage 2: xor and per-byte leading zeros
  always_comb begin
    diff = {key_upper_r, key_lower_r} ^ {rd_data_r.upper, rd_data_r.lower};
    // ipv4 caps the count at 32 with a stop bit below the compared field
    if (key_fam_r == FAM_V4) begin
      diff = {diff[ADDR_W-1 -: V4_BITS], 1'b1, {(ADDR_W - V4_BITS - 1){1'b0}}};
    end
    for (int k = 0; k < N_CHUNKS; k++) begin
      nz[k] = |diff[ADDR_W - 1 - k * CHUNK_W -: CHUNK_W];
      lz[k] = lzc8(diff[ADDR_W - 1 - k * CHUNK_W -: CHUNK_W]);
    end
    fam_eq = (rd_data_r.family == key_fam_r);
  end

  // stage 3: first differing byte gives the count
  always_comb begin
    cnt     = LEN_W'(V6_BITS);
    seen_nz = 1'b0;
    for (int k = 0; k < N_CHUNKS; k++) begin
      if (!seen_nz && p2_nz_r[k]) begin
        seen_nz = 1'b1;
        cnt     = {1'b0, CHUNK_IDX_W'(k), p2_lz_r[k]};
      end
    end
    qual = p2_ok_r && (cnt >= p2_len_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_hit_r <= present_r[iss_r];
    p1_idx_r <= iss_r;
    p2_ok_r  <= p1_hit_r && fam_eq;
    p2_len_r <= rd_data_r.length;
    p2_idx_r <= p1_idx_r;
    p2_nz_r  <= nz;
    for (int k = 0; k < N_CHUNKS; k++) begin
      p2_lz_r[k] <= lz[k];
    end
    p3_q_r   <= qual;
    p3_c_r   <= cnt;
    p3_len_r <= p2_len_r;
    p3_idx_r <= p2_idx_r;
  end

  // stage 4: keep the best (count, length) pair and its winner set
  assign better = !any_r || (p3_c_r > best_c_r) ||
                  ((p3_c_r == best_c_r) && (p3_len_r > best_len_r));
  assign tie    = (p3_c_r == best_c_r) && (p3_len_r == best_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      any_r      <= 1'b0;
      best_c_r   <= '0;
      best_len_r <= '0;
      mask_r     <= '0;
      wcnt_r     <= '0;
      first_r    <= '0;
    end else if (p3_v_r && p3_q_r) begin
      any_r <= 1'b1;
      if (better) begin
        best_c_r   <= p3_c_r;
        best_len_r <= p3_len_r;
        mask_r     <= {{(TABLE_DEPTH - 1){1'b0}}, 1'b1} << p3_idx_r;
        wcnt_r     <= WCNT_W'(1);
        first_r    <= p3_idx_r;
      end else if (tie) begin
        mask_r[p3_idx_r] <= 1'b1;
        wcnt_r           <= wcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (finish) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_found_r  <= any_r;
      out_first_r  <= SLOT_W'(first_r);
      out_mask_r   <= MASK_W'(mask_r);
      out_cnt_r    <= OCNT_W'(wcnt_r);
      out_common_r <= best_c_r;
      out_len_r    <= best_len_r;
    end
  end

  assign empty            = !out_v_r;
  assign out_found        = out_found_r;
  assign out_first_winner = out_first_r;
  assign out_winner_mask  = out_mask_r;
  assign out_winner_count = out_cnt_r;
  assign out_common_bits  = out_common_r;
  assign out_best_length  = out_len_r;

endmodule

>>> rtl/eid_prefix_best_match_top.sv
// ----------------------------------------------------------------------------
// eid_prefix_best_match_top
// longest-prefix best-match table with write and lookup items
//
//   channel   handshake        payload
//   input     push / full      in_cmd, in_entry_slot, in_slot_valid,
//                              in_addr_family, in_prefix_length,
//                              in_addr_upper, in_addr_lower
//   result    empty / pop      out_found, out_first_winner, out_winner_mask,
//                              out_winner_count, out_common_bits,
//                              out_best_length
//
// a write is stored as it is taken from the queue; a lookup is taken from the
// queue, makes one read per entry from the single-port table, drains three
// compare stages and then loads the result register.
// reset clears the present bits at once; there is no clearing pass.
// up to four items wait in the queue ahead of the back end; full rises when
// it fills. a lookup that finishes while a result is still waiting holds
// in its drain step until that result is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eid_prefix_best_match_top #(
  parameter int TABLE_DEPTH = epbm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_cmd,
  input  logic [epbm_pkg::SLOT_W-1:0] in_entry_slot,
  input  logic                        in_slot_valid,
  input  logic                        in_addr_family,
  input  logic [epbm_pkg::LEN_W-1:0]  in_prefix_length,
  input  logic [epbm_pkg::HALF_W-1:0] in_addr_upper,
  input  logic [epbm_pkg::HALF_W-1:0] in_addr_lower,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_found,
  output logic [epbm_pkg::SLOT_W-1:0] out_first_winner,
  output logic [epbm_pkg::MASK_W-1:0] out_winner_mask,
  output logic [epbm_pkg::OCNT_W-1:0] out_winner_count,
  output logic [epbm_pkg::LEN_W-1:0]  out_common_bits,
  output logic [epbm_pkg::LEN_W-1:0]  out_best_length
);
  import epbm_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  work_t q_in, q_out;

  epbm_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_entry_slot   (in_entry_slot),
    .in_slot_valid   (in_slot_valid),
    .in_addr_family  (in_addr_family),
    .in_prefix_length(in_prefix_length),
    .in_addr_upper   (in_addr_upper),
    .in_addr_lower   (in_addr_lower),
    .q_push          (q_push),
    .q_item          (q_in),
    .q_full          (q_full)
  );

  epbm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .item_in (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .item_out(q_out),
    .empty   (q_empty)
  );

  epbm_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_item          (q_out),
    .empty           (empty),
    .pop             (pop),
    .out_found       (out_found),
    .out_first_winner(out_first_winner),
    .out_winner_mask (out_winner_mask),
    .out_winner_count(out_winner_count),
    .out_common_bits (out_common_bits),
    .out_best_length (out_best_length)
  );

endmodule

>>> rtl/epbm_checker.sv
// ----------------------------------------------------------------------------
// epbm_checker
// port-level checks of the prefix best-match block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eid_prefix_best_match_top_macros.svh"

module epbm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic                        out_found,
  input logic [epbm_pkg::SLOT_W-1:0] out_first_winner,
  input logic [epbm_pkg::MASK_W-1:0] out_winner_mask,
  input logic [epbm_pkg::OCNT_W-1:0] out_winner_count,
  input logic [epbm_pkg::LEN_W-1:0]  out_common_bits,
  input logic [epbm_pkg::LEN_W-1:0]  out_best_length
);
  import epbm_pkg::*;

  localparam int OUT_W = 1 + SLOT_W + MASK_W + OCNT_W + 2 * LEN_W;

  logic [OUT_W-1:0] out_bus;
  logic             miss_zero;
  logic             hit_ok;

  assign out_bus = {out_found, out_first_winner, out_winner_mask, out_winner_count,
                    out_common_bits, out_best_length};

  assign miss_zero = (out_first_winner == '0) && (out_winner_mask == '0) &&
                     (out_winner_count == '0) && (out_common_bits == '0) &&
                     (out_best_length == '0);

  assign hit_ok = ($countones(out_winner_mask) == int'(out_winner_count)) &&
                  out_winner_mask[out_first_winner] &&
                  ((out_winner_mask & ((MASK_W'(1) << out_first_winner) - MASK_W'(1)))
                   == '0) &&
                  (out_best_length <= out_common_bits) &&
                  (out_common_bits <= LEN_W'(V6_BITS));

  // a waiting result stays put until popped
  `EPBM_ASSERT_NEXT(a_out_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_bus))

  // a miss reports all zero
  `EPBM_ASSERT_SAME(a_miss_zero, clk, rst_n, !empty && !out_found, miss_zero)

  // a hit: mask, count and first winner agree, and the length fits the count
  `EPBM_ASSERT_SAME(a_hit_consistent, clk, rst_n, !empty && out_found, hit_ok)

  // nothing waits right after reset
  `EPBM_ASSERT_SAME(a_reset_empty, clk, rst_n, $past(!rst_n), empty)

endmodule

bind eid_prefix_best_match_top epbm_checker u_epbm_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the prefix best-match table
//
// items go in through the push/full queue and lookup results come out through
// the empty/pop queue. a shadow table is updated on every accepted write and
// every accepted lookup queues the expected best match, which is compared
// field by field with each popped result. directed table setups come first,
// then random traffic around a few base prefixes, a long result hold-off
// that fills the block, and a final stretch with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import epbm_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int TAIL_CYCLES  = 48;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int FILL_ITEMS   = 60;
  localparam int STEADY_ITEMS = 240;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   first;
    logic [MASK_W-1:0]   mask;
    logic [OCNT_W-1:0]   count;
    logic [LEN_W-1:0]    common;
    logic [LEN_W-1:0]    blen;
  } match_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                push             = 1'b0;
  logic                full;
  logic                in_cmd           = CMD_WRITE;
  logic [SLOT_W-1:0]   in_entry_slot    = '0;
  logic                in_slot_valid    = 1'b0;
  logic                in_addr_family   = FAM_V4;
  logic [LEN_W-1:0]    in_prefix_length = '0;
  logic [HALF_W-1:0]   in_addr_upper    = '0;
  logic [HALF_W-1:0]   in_addr_lower    = '0;
  logic                empty;
  logic                pop              = 1'b0;
  logic                out_found;
  logic [SLOT_W-1:0]   out_first_winner;
  logic [MASK_W-1:0]   out_winner_mask;
  logic [OCNT_W-1:0]   out_winner_count;
  logic [LEN_W-1:0]    out_common_bits;
  logic [LEN_W-1:0]    out_best_length;

  // shadow copy of the table
  bit                  tab_present [DEPTH];
  logic                tab_family  [DEPTH];
  logic [LEN_W-1:0]    tab_length  [DEPTH];
  logic [ADDR_W-1:0]   tab_prefix  [DEPTH];

  match_t              pending_matches[$];
  int                  mismatches    = 0;

  bit                  tx_idle_on    = 1'b0;
  logic                rx_idle_on    = 1'b0;
  int                  hold_requests = 0;
  int                  holds_seen    = 0;
  int                  hold_left     = 0;
  int                  rx_gap_left   = 0;

  // random traffic centers
  logic [ADDR_W-1:0]   v4_seed [4];
  logic [ADDR_W-1:0]   v6_seed [4];
  logic [ADDR_W-1:0]   last_pfx;
  logic [LEN_W-1:0]    last_len;
  logic                last_fam;

  eid_prefix_best_match_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_cmd           (in_cmd),
    .in_entry_slot    (in_entry_slot),
    .in_slot_valid    (in_slot_valid),
    .in_addr_family   (in_addr_family),
    .in_prefix_length (in_prefix_length),
    .in_addr_upper    (in_addr_upper),
    .in_addr_lower    (in_addr_lower),
    .empty            (empty),
    .pop              (pop),
    .out_found        (out_found),
    .out_first_winner (out_first_winner),
    .out_winner_mask  (out_winner_mask),
    .out_winner_count (out_winner_count),
    .out_common_bits  (out_common_bits),
    .out_best_length  (out_best_length)
  );

  always #5 clk = ~clk;

  // leading equal bits within the compared width of the family
  function automatic int shared_bits(logic fam, logic [ADDR_W-1:0] key,
                                     logic [ADDR_W-1:0] pfx);
    logic [ADDR_W-1:0] diff;
    int                lim;
    int                n;
    diff = key ^ pfx;
    lim  = (fam == FAM_V6) ? V6_BITS : V4_BITS;
    n    = 0;
    while (n < lim && !diff[ADDR_W-1-n]) n++;
    return n;
  endfunction

  function automatic match_t lookup_best_match(logic fam, logic [ADDR_W-1:0] key);
    match_t m;
    int     cnt;
    int     top_cnt;
    int     top_len;
    bit     any;
    m       = '0;
    top_cnt = 0;
    top_len = 0;
    any     = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tab_present[i] && tab_family[i] == fam) begin
        cnt = shared_bits(fam, key, tab_prefix[i]);
        if (cnt >= int'(tab_length[i])) begin
          if (!any || cnt > top_cnt || (cnt == top_cnt && int'(tab_length[i]) > top_len)) begin
            top_cnt = cnt;
            top_len = int'(tab_length[i]);
          end
          any = 1'b1;
        end
      end
    end
    if (any) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tab_present[i] && tab_family[i] == fam && int'(tab_length[i]) == top_len &&
            shared_bits(fam, key, tab_prefix[i]) == top_cnt) begin
          if (m.count == 0) m.first = SLOT_W'(i);
          m.mask[i] = 1'b1;
          m.count   = m.count + 1'b1;
        end
      end
      m.found  = 1'b1;
      m.common = LEN_W'(top_cnt);
      m.blen   = LEN_W'(top_len);
    end
    return m;
  endfunction

  // keep the top bits of base, randomize the rest
  function automatic logic [ADDR_W-1:0] blend_addr(logic [ADDR_W-1:0] base, int keep);
    logic [ADDR_W-1:0] noise;
    logic [ADDR_W-1:0] tail;
    noise = {$urandom, $urandom, $urandom, $urandom};
    tail  = (keep >= ADDR_W) ? '0 : ({ADDR_W{1'b1}} >> keep);
    return (base & ~tail) | (noise & tail);
  endfunction

  // offer one item, wait until it is taken, then update the shadow table
  task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot, logic valid, logic fam,
                           logic [LEN_W-1:0] len, logic [ADDR_W-1:0] addr);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push             <= 1'b1;
    in_cmd           <= cmd;
    in_entry_slot    <= slot;
    in_slot_valid    <= valid;
    in_addr_family   <= fam;
    in_prefix_length <= len;
    in_addr_upper    <= addr[ADDR_W-1:HALF_W];
    in_addr_lower    <= addr[HALF_W-1:0];
    @(posedge clk);
    while (full) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      if (slot < DEPTH) begin
        tab_present[slot] = valid;
        tab_family[slot]  = fam;
        tab_length[slot]  = len;
        tab_prefix[slot]  = addr;
      end
    end else begin
      pending_matches.push_back(lookup_best_match(fam, addr));
    end
  endtask

  task automatic write_entry(logic [SLOT_W-1:0] slot, logic valid, logic fam,
                             logic [LEN_W-1:0] len, logic [ADDR_W-1:0] pfx);
    send_item(CMD_WRITE, slot, valid, fam, len, pfx);
  endtask

  // slot, valid and length are don't-care on a lookup, so they are scrambled
  task automatic lookup_key(logic fam, logic [ADDR_W-1:0] key);
    send_item(CMD_LOOKUP, SLOT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), fam,
              LEN_W'($urandom_range(0, 255)), key);
  endtask

  task automatic settle_block();
    push <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_item();
    int                r;
    int                keep;
    logic              fam;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    r    = $urandom_range(0, 99);
    fam  = $urandom_range(0, 1) ? FAM_V6 : FAM_V4;
    base = (fam == FAM_V6) ? v6_seed[2'($urandom_range(0, 3))]
                           : v4_seed[2'($urandom_range(0, 3))];
    if (r < 8) begin
      // noise: every field free
      send_item($urandom_range(0, 1) ? CMD_LOOKUP : CMD_WRITE,
                SLOT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), fam,
                LEN_W'($urandom_range(0, 255)), {$urandom, $urandom, $urandom, $urandom});
    end else if (r < 45) begin
      if ($urandom_range(0, 4) == 0) begin
        // same prefix in another slot makes ties
        write_entry(SLOT_W'($urandom_range(0, 31)), 1'b1, last_fam, last_len, last_pfx);
      end else begin
        keep = (fam == FAM_V6) ? $urandom_range(0, V6_BITS) : $urandom_range(0, V4_BITS);
        if ($urandom_range(0, 2) == 0) keep = (fam == FAM_V6) ? V6_BITS : V4_BITS;
        if ($urandom_range(0, 6) == 0) len = LEN_W'($urandom_range(0, 255));
        else len = LEN_W'($urandom_range(0, (fam == FAM_V6) ? V6_BITS : V4_BITS));
        last_pfx = blend_addr(base, keep);
        last_len = len;
        last_fam = fam;
        write_entry(SLOT_W'($urandom_range(0, 31)), $urandom_range(0, 6) != 0, fam, len,
                    last_pfx);
      end
    end else begin
      keep = (fam == FAM_V6) ? $urandom_range(0, V6_BITS) : $urandom_range(0, V4_BITS);
      if ($urandom_range(0, 1) == 0) keep = (fam == FAM_V6) ? V6_BITS : V4_BITS;
      lookup_key(fam, blend_addr(base, keep));
    end
  endtask

  // nothing stored: both families miss
  task automatic test_empty_table();
    lookup_key(FAM_V4, {ADDR_W{1'b1}});
    lookup_key(FAM_V6, '0);
    settle_block();
  endtask

  task automatic test_directed_entries();
    logic [ADDR_W-1:0] ones;
    logic [ADDR_W-1:0] v6_half;
    ones    = {ADDR_W{1'b1}};
    v6_half = {{HALF_W{1'b1}}, {HALF_W{1'b0}}};
    // ipv4 default route, host route, overlong length and a /24
    write_entry(5'd0, 1'b1, FAM_V4, 8'd0, '0);
    write_entry(5'd31, 1'b1, FAM_V4, 8'd32, {32'hC0A8_0101, {$urandom, $urandom, $urandom}});
    write_entry(5'd1, 1'b1, FAM_V4, 8'd33, {32'hC0A8_0101, 96'h0});
    write_entry(5'd2, 1'b1, FAM_V4, 8'd24, {32'hC0A8_0100, ones[95:0]});
    // low 96 key bits must not matter for ipv4
    lookup_key(FAM_V4, {32'hC0A8_0101, {$urandom, $urandom, $urandom}});
    lookup_key(FAM_V4, {32'hC0A8_0105, 96'h0});
    lookup_key(FAM_V4, {32'h0, ones[95:0]});
    // ipv6 full length, half, overlong and default
    write_entry(5'd3, 1'b1, FAM_V6, 8'd128, ones);
    write_entry(5'd4, 1'b1, FAM_V6, 8'd64, v6_half);
    write_entry(5'd5, 1'b1, FAM_V6, 8'hFF, ones);
    write_entry(5'd6, 1'b1, FAM_V6, 8'd0, '0);
    lookup_key(FAM_V6, ones);
    lookup_key(FAM_V6, {{HALF_W{1'b1}}, 1'b0, {(HALF_W-1){1'b1}}});
    // equal prefix and length in two slots
    write_entry(5'd7, 1'b1, FAM_V6, 8'd64, v6_half);
    // shorter length at the same count loses
    write_entry(5'd8, 1'b1, FAM_V6, 8'd60, v6_half);
    lookup_key(FAM_V6, {{HALF_W{1'b1}}, 1'b0, {(HALF_W-1){1'b1}}});
    // removal still overwrites the other fields
    write_entry(5'd4, 1'b0, FAM_V6, 8'd0, '0);
    lookup_key(FAM_V6, {{HALF_W{1'b1}}, 1'b0, {(HALF_W-1){1'b1}}});
    // only the ipv4 default route matches, with zero shared bits
    lookup_key(FAM_V4, ones);
    write_entry(5'd0, 1'b0, FAM_V4, 8'd0, '0);
    lookup_key(FAM_V4, ones);
    settle_block();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 4; i++) begin
      v4_seed[i] = {$urandom, $urandom, $urandom, $urandom};
      v6_seed[i] = {$urandom, $urandom, $urandom, $urandom};
    end
    last_pfx   = v6_seed[0];
    last_len   = 8'd16;
    last_fam   = FAM_V6;
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    repeat (RANDOM_ITEMS) send_random_item();
    settle_block();
  endtask

  // results are held back while items keep coming, so full must rise
  task automatic test_full_backpressure();
    tx_idle_on = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (FILL_ITEMS) send_random_item();
    settle_block();
  endtask

  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    repeat (STEADY_ITEMS) send_random_item();
    settle_block();
  endtask

  // result side: random pop stalls plus the requested long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left  = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else if (rx_gap_left > 0) begin
      pop <= 1'b0;
      rx_gap_left--;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap_left = $urandom_range(1, 16) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    match_t want;
    match_t got;
    bit     bad;
    if (rst_n && pop && !empty) begin
      got = '{out_found, out_first_winner, out_winner_mask, out_winner_count,
              out_common_bits, out_best_length};
      if (pending_matches.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: found=%0b first=%0d mask=%h count=%0d common=%0d len=%0d",
                   got.found, got.first, got.mask, got.count, got.common, got.blen);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        bad  = (got.found !== want.found) || (got.first !== want.first) ||
               (got.mask !== want.mask) || (got.count !== want.count) ||
               (got.common !== want.common) || (got.blen !== want.blen);
        if (bad) begin
          if (mismatches < 10) begin
            $display("mismatch at %0t ns", $realtime);
            $display("  expected found=%0b first=%0d mask=%h count=%0d common=%0d len=%0d",
                     want.found, want.first, want.mask, want.count, want.common, want.blen);
            $display("  actual   found=%0b first=%0d mask=%h count=%0d common=%0d len=%0d",
                     got.found, got.first, got.mask, got.count, got.common, got.blen);
          end
          mismatches++;
        end
      end
    end
  end

  // ends the run when neither side moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) tab_present[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_directed_entries();
    test_random_mix();
    test_full_backpressure();
    test_steady_stream();
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
